FILE: rtl/core/okl_pkg.sv
// ----------------------------------------------------------------------------
// Ordered key list package
// Types, codes and defaults shared by the ordered key list and its cells.
// ----------------------------------------------------------------------------
package okl_pkg;

	localparam int DEPTH_DEF     = 64;
	localparam int KEY_WIDTH_DEF = 64;

	typedef enum logic [2:0] {
		OP_INSERT = 3'd0,
		OP_DELETE = 3'd1,
		OP_LOOKUP = 3'd2,
		OP_CLEAR  = 3'd3,
		OP_READ   = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_FULL    = 2'd1,
		STAT_MISSING = 2'd2,
		STAT_RANGE   = 2'd3
	} status_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_BUSY = 1'b1
	} fsm_t;

	typedef struct packed {
		logic [2:0]  op;
		logic [63:0] key;
		logic [5:0]  index;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        found;
		logic [5:0]  position;
		logic [6:0]  count;
		logic [63:0] read_key;
	} rsp_t;

	typedef struct packed {
		logic capture;
		logic load;
		logic shift;
	} cell_ctl_t;

endpackage

FILE: rtl/core/okl_cell.sv
// ----------------------------------------------------------------------------
// Ordered key list cell
// Holds one key, compares it with the incoming key, loads a key on an insert
// and takes its upper neighbour's key when the list closes up on a delete.
// ----------------------------------------------------------------------------
module okl_cell import okl_pkg::*; #(
	parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
	input  logic                 clk,
	input  cell_ctl_t            ctl,
	input  logic [KEY_WIDTH-1:0] probe,
	input  logic [KEY_WIDTH-1:0] load_key,
	input  logic [KEY_WIDTH-1:0] next_key,
	input  logic                 live,
	input  logic                 seen_in,
	output logic                 seen_out,
	output logic                 first,
	output logic [KEY_WIDTH-1:0] key
);

	logic [KEY_WIDTH-1:0] key_q;
	logic                 hit_q;
	logic                 hit;

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			hit_q <= (key_q == probe);
		end
		if (ctl.load) begin
			key_q <= load_key;
		end else if (ctl.shift) begin
			key_q <= next_key;
		end
	end

	assign hit      = hit_q & live;
	assign seen_out = seen_in | hit;
	assign first    = hit & ~seen_in;
	assign key      = key_q;

endmodule

FILE: rtl/core/ordered_key_list_with_compaction.sv
// ----------------------------------------------------------------------------
// Ordered key list with compaction
// A list of keys held in insertion order in a row of cells. When a request
// is accepted, every cell registers the compare of its key with the
// request's key; the request is then executed in the busy state, once the
// output register is free, when the first match is found along the chain
// and, on a delete, the matching cell and every later cell take their
// neighbour's key. A finished word waits in the output register while the
// next request is taken. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module ordered_key_list_with_compaction import okl_pkg::*; #(
	parameter int DEPTH     = DEPTH_DEF,
	parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	fsm_t                 state_q, state_d;
	logic [CW-1:0]        cnt_q, cnt_d;
	logic [2:0]           op_q;
	logic [5:0]           idx_q;
	logic [KEY_WIDTH-1:0] rkey_q;
	rsp_t                 rsp_q, rsp_d;
	logic                 rsp_valid_q;

	logic                 accept, exec, out_free, full;
	logic                 do_insert, do_delete;
	logic [DEPTH-1:0]     live_v, tail_v, rsel_v, first_v;
	logic [DEPTH:0]       seen_v;
	logic [KEY_WIDTH-1:0] key_v [DEPTH];
	cell_ctl_t            ctl_v [DEPTH];
	logic [IW-1:0]        pos_w;
	logic [KEY_WIDTH-1:0] rd_w;

	assign out_free = ~rsp_valid_q | ~rsp_stall;
	assign req_stall = (state_q != ST_IDLE);
	assign accept = req_valid & ~req_stall;
	assign exec = (state_q == ST_BUSY) & out_free;
	assign full = (cnt_q == CW'(DEPTH));
	assign do_insert = exec & (op_t'(op_q) == OP_INSERT) & ~full;
	assign do_delete = exec & (op_t'(op_q) == OP_DELETE) & seen_v[DEPTH];
	assign seen_v[0] = 1'b0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		assign live_v[i] = (CW'(i) < cnt_q);
		assign tail_v[i] = (cnt_q == CW'(i));
		if (i < 64) begin : g_rsel
			assign rsel_v[i] = live_v[i] & (idx_q == 6'(i));
		end else begin : g_nosel
			assign rsel_v[i] = 1'b0;
		end
		assign ctl_v[i].capture = accept;
		assign ctl_v[i].load    = do_insert & tail_v[i];
		assign ctl_v[i].shift   = do_delete & seen_v[i+1];

		okl_cell #(
			.KEY_WIDTH(KEY_WIDTH)
		) u_cell (
			.clk     (clk),
			.ctl     (ctl_v[i]),
			.probe   (req.key[KEY_WIDTH-1:0]),
			.load_key(rkey_q),
			.next_key(key_v[(i + 1 < DEPTH) ? i + 1 : i]),
			.live    (live_v[i]),
			.seen_in (seen_v[i]),
			.seen_out(seen_v[i+1]),
			.first   (first_v[i]),
			.key     (key_v[i])
		);
	end

	always_comb begin
		pos_w = '0;
		rd_w  = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (first_v[i]) begin
				pos_w = pos_w | IW'(i);
			end
			if (rsel_v[i]) begin
				rd_w = rd_w | key_v[i];
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_BUSY;
				end
			end
			ST_BUSY: begin
				if (exec) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		logic [1:0] stat;
		logic       fnd;
		logic [5:0] pos;
		logic [63:0] rk;
		stat  = STAT_OK;
		fnd   = 1'b0;
		pos   = '0;
		rk    = '0;
		cnt_d = cnt_q;
		unique case (op_t'(op_q))
			OP_INSERT: begin
				if (full) begin
					stat = STAT_FULL;
				end else begin
					cnt_d = cnt_q + CW'(1);
				end
			end
			OP_DELETE: begin
				if (seen_v[DEPTH]) begin
					fnd   = 1'b1;
					pos   = 6'(pos_w);
					cnt_d = cnt_q - CW'(1);
				end else begin
					stat = STAT_MISSING;
				end
			end
			OP_LOOKUP: begin
				if (seen_v[DEPTH]) begin
					fnd = 1'b1;
					pos = 6'(pos_w);
				end else begin
					stat = STAT_MISSING;
				end
			end
			OP_CLEAR: begin
				cnt_d = '0;
			end
			OP_READ: begin
				if (|rsel_v) begin
					rk = 64'(rd_w);
				end else begin
					stat = STAT_RANGE;
				end
			end
			default: begin
				cnt_d = cnt_q;
			end
		endcase
		rsp_d.status   = stat;
		rsp_d.found    = fnd;
		rsp_d.position = pos;
		rsp_d.count    = 7'(cnt_d);
		rsp_d.read_key = rk;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (exec) begin
				cnt_q       <= cnt_d;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= req.op;
			idx_q  <= req.index;
			rkey_q <= req.key[KEY_WIDTH-1:0];
		end
		if (exec) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

FILE: rtl/core/okl_checker.sv
// ----------------------------------------------------------------------------
// Ordered key list checker
// Watches the ports of the ordered key list and checks its request and result
// handshakes and the consistency of the result words.
// ----------------------------------------------------------------------------
module okl_checker import okl_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid)
		else $error("A stalled result word was withdrawn.");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> $stable(rsp))
		else $error("A stalled result word changed.");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("A request was taken while the previous one was still executing.");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.found |-> rsp.status == STAT_OK)
		else $error("A match was reported with an error status.");

	a_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.found |-> rsp.position == 6'd0)
		else $error("A position was reported without a match.");

endmodule

bind ordered_key_list_with_compaction okl_checker u_okl_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_stall(req_stall),
	.rsp_valid(rsp_valid),
	.rsp_stall(rsp_stall),
	.rsp      (rsp)
);
